// ===== rtl/crcst_pkg.sv =====
// package: widths, codes and shared types for the region card set table
package crcst_pkg;
    localparam int BUCKETS = 16;
    localparam int ENTRIES = 9;
    localparam int CARD_SLOTS = 4;
    localparam int BW = $clog2(BUCKETS);
    localparam int EW = $clog2(ENTRIES + 1);
    localparam int SW = $clog2(CARD_SLOTS);
    localparam int CW = $clog2(CARD_SLOTS + 1);
    localparam int OW = $clog2(ENTRIES + 1);
    localparam int AW = $clog2((ENTRIES + 1) * CARD_SLOTS);
    localparam logic [EW-1:0] NIL = EW'(ENTRIES);

    localparam logic [1:0] ACT_ADD = 2'd0;
    localparam logic [1:0] ACT_HAS = 2'd1;
    localparam logic [1:0] ACT_DEL = 2'd2;
    localparam logic [1:0] ACT_CLR = 2'd3;

    localparam logic [2:0] ST_ADDED   = 3'd0;
    localparam logic [2:0] ST_FOUND   = 3'd1;
    localparam logic [2:0] ST_OVFL    = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_DELETED = 3'd4;
    localparam logic [2:0] ST_ABSENT  = 3'd5;
    localparam logic [2:0] ST_PRESENT = 3'd6;
    localparam logic [2:0] ST_CLEARED = 3'd7;

    typedef enum logic [3:0] {
        S_IDLE, S_HEAD, S_WALK, S_ALLOC, S_SCAN, S_INS, S_UNLINK, S_CLEAR, S_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic rd_head;
        logic walk_step;
        logic alloc;
        logic scan_start;
        logic scan_step;
        logic insert;
        logic unlink;
        logic clear_step;
        logic [2:0] status;
        logic set_status;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] action;
        logic cur_nil;
        logic key_hit;
        logic chain_done;
        logic can_alloc;
        logic scan_done;
        logic card_hit;
        logic set_room;
    } sts_t;
endpackage

// ===== rtl/crcst_datapath.sv =====
// datapath: table storage, chain walker, card scanner and allocator
module crcst_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  crcst_pkg::cmd_t      cmd,
    input  logic [1:0]           in_action,
    input  logic [15:0]          in_region,
    input  logic [15:0]          in_card,
    output crcst_pkg::sts_t      sts,
    output logic [2:0]           status,
    output logic [crcst_pkg::OW-1:0] occupied
);
    import crcst_pkg::*;

    logic [EW-1:0] head_mem [BUCKETS];
    logic [BUCKETS-1:0] head_vld_reg;
    logic [15:0] key_mem [ENTRIES];
    logic [EW-1:0] next_mem [ENTRIES];
    logic [CW-1:0] cnt_mem [ENTRIES];
    logic [15:0] card_mem [ENTRIES*CARD_SLOTS];

    logic [1:0] act_reg;
    logic [15:0] region_reg, card_reg;
    logic [EW-1:0] cur_reg, prev_reg, free_reg, fresh_reg;
    logic [EW-1:0] steps_reg;
    logic [OW-1:0] occ_reg;
    logic [SW:0] slot_reg;
    logic [CW-1:0] cnt_reg;
    logic [2:0] status_reg;
    logic [15:0] card_rd_reg;
    logic [15:0] key_q;
    logic [EW-1:0] next_q;
    logic [CW-1:0] cnt_q;

    logic [BW-1:0] bucket;
    logic [EW-1:0] cur_idx;
    logic [SW:0] rd_slot;
    logic [AW-1:0] card_addr, rd_addr;

    assign bucket = BW'(region_reg % BUCKETS);
    assign cur_idx = cur_reg;
    assign card_addr = AW'(cur_idx * CARD_SLOTS) + AW'(slot_reg[SW-1:0]);
    // card store read address follows the slot the scan will look at next cycle
    assign rd_slot = cmd.scan_start ? '0 : (cmd.scan_step ? slot_reg + 1'b1 : slot_reg);
    assign rd_addr = AW'(cur_idx * CARD_SLOTS) + AW'(rd_slot[SW-1:0]);

    // combinational reads of small entry tables, indexed by cur only
    always_comb begin
        key_q = key_mem[cur_idx[EW-1:0] < EW'(ENTRIES) ? cur_idx : '0];
        next_q = next_mem[cur_idx < EW'(ENTRIES) ? cur_idx : '0];
        cnt_q = cnt_mem[cur_idx < EW'(ENTRIES) ? cur_idx : '0];
    end

    always_comb begin
        sts.action = act_reg;
        sts.cur_nil = (cur_reg >= NIL);
        sts.key_hit = (key_q == region_reg);
        sts.chain_done = (steps_reg >= EW'(ENTRIES));
        sts.can_alloc = (free_reg < NIL) || (fresh_reg < NIL);
        sts.scan_done = ((SW+1)'(slot_reg) >= (SW+1)'(cnt_reg))
                        || (slot_reg >= (SW+1)'(CARD_SLOTS));
        sts.card_hit = (card_rd_reg == card_reg);
        sts.set_room = (cnt_reg < CW'(CARD_SLOTS - 1));
    end

    assign status = status_reg;
    assign occupied = occ_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_vld_reg <= '0;
            free_reg <= NIL;
            fresh_reg <= '0;
            occ_reg <= '0;
        end else begin
            if (cmd.clear_step) begin
                head_vld_reg <= '0;
                free_reg <= NIL;
                fresh_reg <= '0;
                occ_reg <= '0;
            end
            if (cmd.alloc) begin
                head_vld_reg[bucket] <= 1'b1;
                occ_reg <= occ_reg + 1'b1;
                if (free_reg < NIL) free_reg <= next_mem[free_reg];
                else fresh_reg <= fresh_reg + 1'b1;
            end
            if (cmd.unlink) begin
                if (prev_reg >= NIL) head_vld_reg[bucket] <= 1'b1;
                free_reg <= cur_reg;
                if (occ_reg != '0) occ_reg <= occ_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        card_rd_reg <= card_mem[rd_addr];
        if (cmd.load) begin
            act_reg <= in_action;
            region_reg <= in_region;
            card_reg <= in_card;
        end
        if (cmd.rd_head) begin
            cur_reg <= head_vld_reg[bucket] ? head_mem[bucket] : NIL;
            prev_reg <= NIL;
            steps_reg <= '0;
        end
        if (cmd.walk_step) begin
            prev_reg <= cur_reg;
            cur_reg <= next_q;
            steps_reg <= steps_reg + 1'b1;
        end
        if (cmd.alloc) begin
            logic [EW-1:0] e;
            e = (free_reg < NIL) ? free_reg : fresh_reg;
            key_mem[e] <= region_reg;
            cnt_mem[e] <= '0;
            next_mem[e] <= head_vld_reg[bucket] ? head_mem[bucket] : NIL;
            head_mem[bucket] <= e;
            cur_reg <= e;
        end
        if (cmd.scan_start) begin
            slot_reg <= '0;
            cnt_reg <= cnt_q;
        end
        if (cmd.scan_step) slot_reg <= slot_reg + 1'b1;
        if (cmd.insert) begin
            card_mem[card_addr] <= card_reg;
            cnt_mem[cur_idx] <= cnt_reg + 1'b1;
        end
        if (cmd.unlink) begin
            if (prev_reg >= NIL) head_mem[bucket] <= next_q;
            else next_mem[prev_reg] <= next_q;
            next_mem[cur_idx] <= free_reg;
        end
        if (cmd.set_status) status_reg <= cmd.status;
    end
endmodule

// ===== rtl/crcst_ctrl.sv =====
// controller: sequences chain walk, allocation, card scan, unlink and clear per item
module crcst_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  crcst_pkg::sts_t  sts,
    output crcst_pkg::cmd_t  cmd
);
    import crcst_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_valid) state_next = S_HEAD;
            S_HEAD: state_next = (sts.action == ACT_CLR) ? S_CLEAR : S_WALK;
            S_WALK: begin
                if (sts.cur_nil || sts.chain_done) begin
                    if (sts.action == ACT_ADD)
                        state_next = sts.can_alloc ? S_ALLOC : S_OUT;
                    else state_next = S_OUT;
                end else if (sts.key_hit) begin
                    state_next = (sts.action == ACT_DEL) ? S_UNLINK : S_ALLOC;
                end
            end
            S_ALLOC: state_next = S_SCAN;
            S_SCAN: begin
                if (sts.scan_done) state_next = sts.set_room &&
                    (sts.action == ACT_ADD) ? S_INS : S_OUT;
                else if (sts.card_hit) state_next = S_OUT;
            end
            S_INS: state_next = S_OUT;
            S_UNLINK: state_next = S_OUT;
            S_CLEAR: state_next = S_OUT;
            S_OUT: if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        in_ready = (state_reg == S_IDLE);
        out_valid = (state_reg == S_OUT);
        case (state_reg)
            S_IDLE: cmd.load = in_valid;
            S_HEAD: begin
                cmd.rd_head = 1'b1;
                if (sts.action == ACT_CLR) cmd.clear_step = 1'b1;
            end
            S_WALK: begin
                if (sts.cur_nil || sts.chain_done) begin
                    cmd.set_status = 1'b1;
                    if (sts.action == ACT_ADD) begin
                        cmd.alloc = sts.can_alloc;
                        cmd.status = ST_FULL;
                    end else cmd.status = ST_ABSENT;
                end else if (sts.key_hit) begin
                    // found entry: reuse alloc state as a plain pass to the scan
                end else cmd.walk_step = 1'b1;
            end
            S_ALLOC: cmd.scan_start = 1'b1;
            S_SCAN: begin
                if (sts.scan_done) begin
                    cmd.set_status = 1'b1;
                    if (sts.action == ACT_ADD)
                        cmd.status = sts.set_room ? ST_ADDED : ST_OVFL;
                    else cmd.status = ST_ABSENT;
                end else if (sts.card_hit) begin
                    cmd.set_status = 1'b1;
                    cmd.status = (sts.action == ACT_ADD) ? ST_FOUND : ST_PRESENT;
                end else cmd.scan_step = 1'b1;
            end
            S_INS: cmd.insert = 1'b1;
            S_UNLINK: begin
                cmd.unlink = 1'b1;
                cmd.set_status = 1'b1;
                cmd.status = ST_DELETED;
            end
            S_CLEAR: begin
                cmd.set_status = 1'b1;
                cmd.status = ST_CLEARED;
            end
            default: ;
        endcase
    end
endmodule

// ===== rtl/chained_region_card_set_table.sv =====
// top level: region card set hash table with chained buckets
// usage:
//   s_axis beats carry one command each: add card, contains card,
//   delete region or clear table. every beat gives exactly one m_axis beat
//   with the status code and the number of regions held afterwards.
//   one command at a time: s_axis_tready is high only while idle, so the
//   next beat is taken in the cycle after the result beat leaves, at the earliest.
//   steps from accept to result with no stall: head read, a walk step for
//   each chain entry visited and a last one at the chain end, entry
//   set-up, a scan of the card slots visited, insert or unlink, then the
//   result beat.
//   clear walks no table: bucket heads carry valid bits cleared at once.
//   a stalled result holds m_axis_tdata and no new beat is taken until it
//   leaves. reset empties the table at once; no clearing pass.
module chained_region_card_set_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // action[1:0], region[17:2], card[33:18]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata   // status[2:0], occupied[6:3]
);
    import crcst_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic [2:0] status;
    logic [OW-1:0] occupied;

    crcst_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .sts(sts), .cmd(cmd)
    );

    crcst_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd),
        .in_action(s_axis_tdata[1:0]), .in_region(s_axis_tdata[17:2]),
        .in_card(s_axis_tdata[33:18]),
        .sts(sts), .status(status), .occupied(occupied)
    );

    assign m_axis_tdata = {1'b0, 4'(occupied), status};

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_axis_tready && m_axis_tvalid)) else $error("busy overlap");
    a_occ_max: assert property (@(posedge aclk) disable iff (!aresetn)
        occupied <= OW'(ENTRIES)) else $error("occupancy overrun");
    a_clr: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && status == ST_CLEARED) |-> occupied == '0)
        else $error("clear left regions");
endmodule
